[hdl/compacting_named_byte_heap_core_defines.svh]
// Assertion macros shared by the checker of the byte heap core.
// Depends on nothing; included by the checker file.
`ifndef COMPACTING_NAMED_BYTE_HEAP_CORE_DEFINES_SVH
`define COMPACTING_NAMED_BYTE_HEAP_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define CNBH_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CNBH_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/cnbh_pkg.sv]
// Package of the byte heap core: sizes, and mode and status codes.
// Depends on nothing.
package cnbh_pkg;
  localparam int HEAP_BYTES_DEF = 256;
  localparam int NAME_BITS_DEF = 8;
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
endpackage

[hdl/cnbh_if.sv]
// Valid/ready channel interfaces of the byte heap core.
// Depends on nothing.
interface cnbh_in_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [7:0] name_id;
  logic [63:0] value;
  logic [3:0] byte_count;
  logic [7:0] address;
  modport source (output valid, mode, name_id, value, byte_count, address, input ready);
  modport sink (input valid, mode, name_id, value, byte_count, address, output ready);
endinterface

interface cnbh_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [8:0] free_bytes;
  logic [7:0] read_data;
  modport source (output valid, status, free_bytes, read_data, input ready);
  modport sink (input valid, status, free_bytes, read_data, output ready);
endinterface

[hdl/compacting_named_byte_heap_core.sv]
// Byte heap with named chunks: a valid/ready input channel of commands and
// a valid/ready output channel with one result item per command.
// Channels: in (mode, name_id, value, byte_count, address) and out (status,
// free_bytes, read_data). An item is taken when valid and ready are high.
// After reset a clearing pass writes zero to each heap byte, one a cycle,
// while in_ready stays low.
// Steps: a read reads one heap byte; an allocate writes one heap byte per
// cycle; a free searches the chunk table one entry at a time, then moves
// each heap byte above the chunk down and shifts the later table entries
// down one by one. The heap and table memories each have one port with a
// registered read.
// One item is in work at a time. The result waits in an output register;
// a stalled receiver holds it, and the next item is taken once it is gone.
// Depends on cnbh_pkg and the interfaces in cnbh_if.
module compacting_named_byte_heap_core #(
  parameter int HEAP_BYTES = cnbh_pkg::HEAP_BYTES_DEF,
  parameter int NAME_BITS = cnbh_pkg::NAME_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  cnbh_in_if.sink in_ch,
  cnbh_out_if.source out_ch
);
  import cnbh_pkg::*;
  localparam int AW = $clog2(HEAP_BYTES);
  localparam int CW = AW + 1;

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_ARD = 4'd2, S_AWR = 4'd3,
    S_ATAB = 4'd4, S_FSRCH = 4'd5, S_FCHK = 4'd6, S_MRD = 4'd7, S_MWR = 4'd8,
    S_TRD = 4'd9, S_TWR = 4'd10, S_OUT = 4'd11, S_RRD = 4'd12, S_RDAT = 4'd13;

  logic [7:0] heap_mem [HEAP_BYTES];
  logic [NAME_BITS-1:0] name_mem [HEAP_BYTES];
  logic [CW-1:0] len_mem [HEAP_BYTES];

  logic [3:0] state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt, cnt_r, cnt_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt, base_r, base_nxt, len_r, len_nxt;
  logic [3:0] k_r, k_nxt, bc_r, bc_nxt;
  logic [NAME_BITS-1:0] name_r, name_nxt;
  logic [63:0] val_r, val_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [1:0] st_r, st_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic ovalid_r, ovalid_nxt;
  logic last_same_r, last_same_nxt;

  // Heap port.
  logic h_we;
  logic [AW-1:0] h_addr;
  logic [7:0] h_wd, h_q;
  // Table port.
  logic t_we;
  logic [AW-1:0] t_addr;
  logic [NAME_BITS-1:0] t_wn, t_qn;
  logic [CW-1:0] t_wl, t_ql;

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_addr] <= h_wd;
    h_q <= heap_mem[h_addr];
    if (t_we) begin
      name_mem[t_addr] <= t_wn;
      len_mem[t_addr] <= t_wl;
    end
    t_qn <= name_mem[t_addr];
    t_ql <= len_mem[t_addr];
  end

  logic [CW:0] src_w;
  logic [CW-1:0] room_w;
  logic [3:0] bc_sat;

  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; cnt_nxt = cnt_r; ptr_nxt = ptr_r;
    base_nxt = base_r; len_nxt = len_r; k_nxt = k_r; bc_nxt = bc_r;
    name_nxt = name_r; val_nxt = val_r; addr_nxt = addr_r; st_nxt = st_r;
    rd_nxt = rd_r; ovalid_nxt = ovalid_r; last_same_nxt = last_same_r;
    h_we = 1'b0; h_addr = ptr_r[AW-1:0]; h_wd = 8'd0;
    t_we = 1'b0; t_addr = ptr_r[AW-1:0]; t_wn = name_r; t_wl = len_r;
    src_w = {1'b0, ptr_r} + {1'b0, len_r};
    room_w = CW'(HEAP_BYTES) - fill_r;
    bc_sat = (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
    in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_CLR: begin
        h_we = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == CW'(HEAP_BYTES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          name_nxt = NAME_BITS'(in_ch.name_id);
          val_nxt = in_ch.value; addr_nxt = in_ch.address; bc_nxt = bc_sat;
          st_nxt = ST_DONE; rd_nxt = 8'd0; k_nxt = 4'd0;
          case (in_ch.mode)
            MODE_ALLOC: begin
              if (CW'(bc_sat) > room_w) begin
                st_nxt = ST_NO_ROOM; state_nxt = S_OUT;
              end else if (bc_sat == 4'd0) begin
                state_nxt = S_OUT;
              end else begin
                ptr_nxt = cnt_r - 1'b1; state_nxt = S_ARD;
              end
            end
            MODE_FREE: begin
              ptr_nxt = '0; base_nxt = '0; state_nxt = S_FSRCH;
            end
            MODE_READ: begin
              if (32'(in_ch.address) < HEAP_BYTES) state_nxt = S_RRD;
              else state_nxt = S_OUT;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_ARD: begin
        // Table read of the last entry issued; heap writes follow.
        t_addr = ptr_r[AW-1:0];
        state_nxt = S_AWR;
      end
      S_AWR: begin
        if (k_r == 4'd0) last_same_nxt = (cnt_r != '0) && (t_qn == name_r);
        if (k_r == 4'd0) len_nxt = t_ql;
        h_we = 1'b1;
        h_addr = AW'(fill_r + CW'(k_r));
        h_wd = val_r[8*k_r +: 8];
        k_nxt = k_r + 1'b1;
        if (k_r + 1'b1 == bc_r) state_nxt = S_ATAB;
      end
      S_ATAB: begin
        fill_nxt = fill_r + CW'(bc_r);
        t_we = 1'b1;
        if (last_same_r) begin
          t_addr = AW'(cnt_r - 1'b1); t_wl = len_r + CW'(bc_r);
          state_nxt = S_OUT;
        end else if (32'(cnt_r) < HEAP_BYTES) begin
          t_addr = cnt_r[AW-1:0]; t_wl = CW'(bc_r);
          cnt_nxt = cnt_r + 1'b1; state_nxt = S_OUT;
        end else begin
          t_we = 1'b0; state_nxt = S_OUT;
        end
      end
      S_FSRCH: begin
        if (ptr_r >= cnt_r) begin
          st_nxt = ST_NOT_FOUND; state_nxt = S_OUT;
        end else begin
          t_addr = ptr_r[AW-1:0]; state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        if (t_qn == name_r) begin
          len_nxt = t_ql;
          k_nxt = 4'd0;
          ptr_nxt = base_r; state_nxt = S_MRD;
          base_nxt = ptr_r; // table index of the freed entry
        end else begin
          base_nxt = base_r + t_ql; ptr_nxt = ptr_r + 1'b1; state_nxt = S_FSRCH;
        end
      end
      S_MRD: begin
        if (ptr_r >= fill_r || 32'(ptr_r) >= HEAP_BYTES) begin
          fill_nxt = (len_r <= fill_r) ? fill_r - len_r : '0;
          ptr_nxt = base_r; state_nxt = S_TRD;
        end else begin
          h_addr = AW'(src_w); state_nxt = S_MWR;
        end
      end
      S_MWR: begin
        h_we = 1'b1;
        h_wd = (src_w < {1'b0, fill_r} && src_w < (CW+1)'(HEAP_BYTES)) ? h_q : 8'd0;
        ptr_nxt = ptr_r + 1'b1; state_nxt = S_MRD;
      end
      S_TRD: begin
        if (ptr_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1; state_nxt = S_OUT;
        end else begin
          t_addr = AW'(ptr_r + 1'b1); state_nxt = S_TWR;
        end
      end
      S_TWR: begin
        t_we = 1'b1; t_wn = t_qn; t_wl = t_ql;
        ptr_nxt = ptr_r + 1'b1; state_nxt = S_TRD;
      end
      S_RRD: begin
        h_addr = AW'(addr_r); state_nxt = S_RDAT;
      end
      S_RDAT: begin
        rd_nxt = h_q; state_nxt = S_OUT;
      end
      S_OUT: begin
        ovalid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; fill_r <= '0; cnt_r <= '0; ptr_r <= '0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; cnt_r <= cnt_nxt; ptr_r <= ptr_nxt;
      ovalid_r <= ovalid_nxt;
    end
    base_r <= base_nxt; len_r <= len_nxt; k_r <= k_nxt; bc_r <= bc_nxt;
    name_r <= name_nxt; val_r <= val_nxt; addr_r <= addr_nxt; st_r <= st_nxt;
    rd_r <= rd_nxt; last_same_r <= last_same_nxt;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.status = st_r;
  assign out_ch.free_bytes = 9'(CW'(HEAP_BYTES) - fill_r);
  assign out_ch.read_data = rd_r;
endmodule

[hdl/cnbh_checker.sv]
// Port-level checker of the byte heap core and its bind statement.
// Depends on cnbh_pkg, the defines header and the top level's ports.
`include "compacting_named_byte_heap_core_defines.svh"
module cnbh_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic [8:0] out_free_bytes,
  input logic [7:0] out_read_data
);
  import cnbh_pkg::*;
  // A new item is never taken while a result waits.
  `CNBH_ASSERT_IMPL(no_take_while_full, clk, rst_n, out_valid, !in_ready)
  // A stalled result holds its status and free byte count.
  `CNBH_ASSERT_NEXT(hold_stalled, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_free_bytes))
  // Status is never the unused code.
  `CNBH_ASSERT_IMPL(status_legal, clk, rst_n, out_valid,
    out_status == ST_DONE || out_status == ST_NO_ROOM || out_status == ST_NOT_FOUND)
  // Only a completed command delivers data: a refused one reads zero.
  `CNBH_ASSERT_IMPL(fail_reads_zero, clk, rst_n, out_valid && out_status != ST_DONE,
    out_read_data == 8'd0)
endmodule

bind compacting_named_byte_heap_core cnbh_checker u_cnbh_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status),
  .out_free_bytes(out_ch.free_bytes), .out_read_data(out_ch.read_data)
);

[bench/compacting_named_byte_heap_core_tb.sv]
// Self-checking bench for the compacting named byte heap core: a local
// heap predictor drives a small scoreboard of expected result items.
// Depends on cnbh_pkg, the interfaces in cnbh_if and the core itself.
`timescale 1ns / 1ps

class heap_scoreboard;
  logic [7:0] heap_mem [256];
  int unsigned fill;
  logic [7:0] names [$];
  int unsigned lens [$];
  logic [1:0] want_status [$];
  logic [8:0] want_free [$];
  logic [7:0] want_rd [$];
  int errors;
  int checked;
  int allocs, frees, reads, refused, missing;

  function new();
    foreach (heap_mem[i]) heap_mem[i] = 8'd0;
    fill = 0;
    errors = 0;
    checked = 0;
    allocs = 0;
    frees = 0;
    reads = 0;
    refused = 0;
    missing = 0;
  endfunction

  // Works out the effect of one accepted item and queues its result.
  function void note_command(logic [1:0] mode, logic [7:0] nm, logic [63:0] val,
                             logic [3:0] cnt, logic [7:0] addr);
    logic [1:0] st;
    logic [7:0] rd;
    int unsigned n, idx, base, len, src;
    st = cnbh_pkg::ST_DONE;
    rd = 8'd0;
    if (mode == cnbh_pkg::MODE_ALLOC) begin
      allocs++;
      n = (cnt > 8) ? 8 : cnt;
      if (n > 256 - fill) begin
        st = cnbh_pkg::ST_NO_ROOM;
        refused++;
      end else if (n != 0) begin
        for (int k = 0; k < n; k++) heap_mem[fill + k] = val[8*k +: 8];
        fill += n;
        if (names.size() > 0 && names[$] == nm) begin
          lens[$] = lens[$] + n;
        end else begin
          names.push_back(nm);
          lens.push_back(n);
        end
      end
    end else if (mode == cnbh_pkg::MODE_FREE) begin
      frees++;
      idx = 0;
      base = 0;
      while (idx < names.size() && names[idx] != nm) begin
        base += lens[idx];
        idx++;
      end
      if (idx >= names.size()) begin
        st = cnbh_pkg::ST_NOT_FOUND;
        missing++;
      end else begin
        len = lens[idx];
        for (int unsigned a = base; a < fill; a++) begin
          src = a + len;
          heap_mem[a] = (src < fill) ? heap_mem[src] : 8'd0;
        end
        fill = (len <= fill) ? fill - len : 0;
        names.delete(idx);
        lens.delete(idx);
      end
    end else if (mode == cnbh_pkg::MODE_READ) begin
      reads++;
      rd = heap_mem[addr];
    end
    want_status.push_back(st);
    want_free.push_back(9'(256 - fill));
    want_rd.push_back(rd);
  endfunction

  function void check_result(logic [1:0] st, logic [8:0] fb, logic [7:0] rd);
    logic [1:0] es;
    logic [8:0] ef;
    logic [7:0] er;
    if (want_status.size() == 0) begin
      $error("result item with no expectation waiting");
      errors++;
      return;
    end
    es = want_status.pop_front();
    ef = want_free.pop_front();
    er = want_rd.pop_front();
    checked++;
    if (st !== es) begin
      $error("status: expected %0d, actual %0d", es, st);
      errors++;
    end
    if (fb !== ef) begin
      $error("free_bytes: expected %0d, actual %0d", ef, fb);
      errors++;
    end
    if (rd !== er) begin
      $error("read_data: expected %0h, actual %0h", er, rd);
      errors++;
    end
  endfunction

  function int pending();
    return want_status.size();
  endfunction
endclass

module compacting_named_byte_heap_core_tb;
  import cnbh_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  cnbh_in_if in_ch();
  cnbh_out_if out_ch();
  heap_scoreboard board;
  bit hold_sink_open;

  compacting_named_byte_heap_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: random stalls, sampled on the rising edge.
  initial begin
    out_ch.ready = 1'b0;
    board = new();
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.status, out_ch.free_bytes, out_ch.read_data);
      out_ch.ready <= hold_sink_open ? 1'b1 : (pick_gap() == 0);
    end
  end

  // Valid stays high from one item to the next when there is no gap, so
  // that each edge sees a single assignment to it.
  task automatic send_command(logic [1:0] mode, logic [7:0] nm, logic [63:0] val,
                              logic [3:0] cnt, logic [7:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.name_id <= nm;
    in_ch.value <= val;
    in_ch.byte_count <= cnt;
    in_ch.address <= addr;
    do @(posedge clk); while (!in_ch.ready);
    board.note_command(mode, nm, val, cnt, addr);
  endtask

  task automatic drain_all();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_value();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int r;
    logic [7:0] nm;
    hold_sink_open = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ALLOC;
    in_ch.name_id = 8'd0;
    in_ch.value = 64'd0;
    in_ch.byte_count = 4'd0;
    in_ch.address = 8'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: read of a cleared heap, zero and oversized counts,
    // growth of the last chunk, missing name, unused mode, extremes.
    send_command(MODE_READ, 8'd0, 64'd0, 4'd0, 8'd255);
    send_command(MODE_ALLOC, 8'd7, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 8'd0);
    send_command(MODE_ALLOC, 8'd0, 64'h0123_4567_89AB_CDEF, 4'd1, 8'd0);
    send_command(MODE_ALLOC, 8'd0, 64'hFEDC_BA98_7654_3210, 4'd8, 8'd0);
    send_command(MODE_ALLOC, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 8'd0);
    send_command(MODE_ALLOC, 8'd9, 64'hA5A5_5A5A_A5A5_5A5A, 4'd3, 8'd0);
    send_command(MODE_READ, 8'd0, 64'd0, 4'd0, 8'd0);
    send_command(MODE_READ, 8'd0, 64'd0, 4'd0, 8'd9);
    send_command(MODE_FREE, 8'd123, 64'd0, 4'd0, 8'd0);
    send_command(MODE_FREE, 8'd0, 64'd0, 4'd0, 8'd0);
    send_command(MODE_READ, 8'd0, 64'd0, 4'd0, 8'd2);
    send_command(2'd3, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 8'hFF);
    // Fill the heap to the brim, then get refused.
    while (256 - board.fill >= 8)
      send_command(MODE_ALLOC, 8'($urandom_range(0, 3)), rand_value(), 4'd8, 8'd0);
    send_command(MODE_ALLOC, 8'd1, rand_value(), 4'd8, 8'd0);
    send_command(MODE_ALLOC, 8'd2, rand_value(), 4'(256 - board.fill), 8'd0);
    send_command(MODE_ALLOC, 8'd2, rand_value(), 4'd1, 8'd0);
    send_command(MODE_READ, 8'd0, 64'd0, 4'd0, 8'd255);
    send_command(MODE_FREE, 8'd255, 64'd0, 4'd0, 8'd0);

    // The sender holds off until every expected result has come back.
    drain_all();

    for (int i = 0; i < 1000; i++) begin
      r = $urandom_range(0, 99);
      // Few names so that frees hit and the last chunk often grows.
      nm = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 7));
      if (r < 45) begin
        send_command(MODE_ALLOC, nm, rand_value(),
                     ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 8)),
                     8'd0);
      end else if (r < 70) begin
        send_command(MODE_FREE, nm, rand_value(), 4'($urandom()), 8'($urandom()));
      end else if (r < 97) begin
        send_command(MODE_READ, nm, rand_value(), 4'($urandom()),
                     ($urandom_range(0, 3) == 0) ? 8'($urandom())
                       : 8'($urandom_range(0, board.fill)));
      end else begin
        send_command(2'd3, nm, rand_value(), 4'($urandom()), 8'($urandom()));
      end
      if (i == 500) drain_all();
    end

    hold_sink_open = 1'b1;
    drain_all();
    repeat (1200) @(posedge clk);
    $display("Checked %0d results: %0d allocates (%0d refused), %0d frees (%0d missing),",
             board.checked, board.allocs, board.refused, board.frees, board.missing);
    $display("  %0d reads; heap ended with %0d bytes in use.", board.reads, board.fill);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
